// ===== hdl/crc8ps_pkg.sv =====
`default_nettype none
package crc8ps_pkg;

  localparam logic [7:0] CrcInit    = 8'hFF;
  localparam logic [7:0] CrcTopBit  = 8'h80;
  localparam logic [7:0] PolyReset  = 8'h1D;

  typedef struct packed {
    logic       en;
    logic       last;
    logic [7:0] data;
  } step_t;

  function automatic logic [7:0] crc_absorb(input logic [7:0] crc,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
    logic [7:0] r;
    r = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if ((r & CrcTopBit) != 8'h00) begin
        r = {r[6:0], 1'b0} ^ poly;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/crc8ps_core.sv =====
`default_nettype none
module crc8ps_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire crc8ps_pkg::step_t   step,
  input  wire logic [7:0]          poly,
  output logic [7:0]               result
);
  import crc8ps_pkg::*;

  logic [7:0] crc;
  logic [7:0] crc_next;

  assign result = crc_absorb(crc, step.data, poly);

  always_comb begin
    crc_next = crc;
    if (step.en) begin
      crc_next = step.last ? CrcInit : result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CrcInit;
    end else begin
      crc <= crc_next;
    end
  end

`ifndef SYNTH
  // message boundary restarts the register
  a_reload: assert property (@(posedge clk) disable iff (rst)
    (step.en && step.last) |=> (crc == CrcInit))
    else $error("crc not reloaded after last byte");
`endif

endmodule
`default_nettype wire

// ===== hdl/crc8ps_out_reg.sv =====
`default_nettype none
module crc8ps_out_reg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire logic [7:0] value,
  input  wire logic       stall,
  output logic            valid,
  output logic [7:0]      data
);
  import crc8ps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= value;
    end
  end

`ifndef SYNTH
  // never overwrite a request that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (valid && stall) |-> !load)
    else $error("result overwritten while stalled");
`endif

endmodule
`default_nettype wire

// ===== hdl/crc8_programmable_poly_stream.sv =====
`default_nettype none
// Flow: a byte accepted into s1 updates the CRC as it leaves s1 and, if last,
//   raises crc_valid at that edge; a last byte behind a stalled result waits.
// Throughput: one byte per cycle; non-last bytes keep flowing while a result
//   waits, a second last byte stalls the input until that result is taken.
// Reset (rst, synchronous, active high): CRC = 0xFF, polynomial = 0x1D,
//   no request held.
module crc8_programmable_poly_stream (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       poly_we,
  input  wire logic [7:0] poly_wdata,
  input  wire logic       data_valid,
  output logic            data_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       is_last,
  output logic            crc_valid,
  input  wire logic       crc_stall,
  output logic [7:0]      crc_value
);
  import crc8ps_pkg::*;

  logic       poly;
  logic [7:0] crc_poly;
  logic       s1_valid;
  logic       s1_last;
  logic [7:0] s1_data;
  logic       s1_adv;
  logic       accept;
  step_t      step;
  logic [7:0] result;

  assign s1_adv     = s1_valid && (!s1_last || !crc_valid || !crc_stall);
  assign data_stall = s1_valid && !s1_adv;
  assign accept     = data_valid && !data_stall;
  assign poly       = poly_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_poly <= PolyReset;
    end else if (poly) begin
      crc_poly <= poly_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data <= data_byte;
      s1_last <= is_last;
    end
  end

  always_comb begin
    step.en   = s1_adv;
    step.last = s1_last;
    step.data = s1_data;
  end

  crc8ps_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .poly   (crc_poly),
    .result (result)
  );

  crc8ps_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (s1_adv && s1_last),
    .value (result),
    .stall (crc_stall),
    .valid (crc_valid),
    .data  (crc_value)
  );

`ifndef SYNTH
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    data_stall |-> (s1_valid && s1_last))
    else $error("input stalled without a pending last byte");

  a_last_out: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last) |=> crc_valid)
    else $error("last byte gave no request");

  a_blocked: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && crc_valid && crc_stall) |-> data_stall)
    else $error("last byte not held behind stalled result");
`endif

endmodule
`default_nettype wire
